// ----- sv/wbn_pkg.sv -----
// shared types and constants of the windowed baseline normalizer
`timescale 1ns / 1ps
package wbn_pkg;
	localparam int HISTORY_DEPTH_DEF = 256;

	typedef logic [1:0] func_t;
	localparam func_t FUNC_ADD    = 2'd0;
	localparam func_t FUNC_UPDATE = 2'd1;
	localparam func_t FUNC_NORM   = 2'd2;
	localparam func_t FUNC_CLEAR  = 2'd3;

	localparam int CH_W = 16;
	localparam int DAYS_W = 9;
	localparam int STAMP_W = 32;
	localparam int MASK_W = 4;
	localparam int SPAN_W = 26;
	localparam logic [16:0] SEC_PER_DAY = 17'd86400;
	localparam logic [DAYS_W-1:0] WINDOW_RESET = 9'd7;

	localparam logic [CH_W-1:0] BASE_HR_RESET   = 16'd17920;
	localparam logic [CH_W-1:0] BASE_HRV_RESET  = 16'd12800;
	localparam logic [CH_W-1:0] BASE_SC_RESET   = 16'd1280;
	localparam logic [CH_W-1:0] BASE_TEMP_RESET = 16'd9344;

	localparam logic [CH_W:0] Q15_ONE = 17'd32768;

	localparam int DVD_W = 32;
	localparam int DVS_W = 16;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;
endpackage

// ----- sv/wbn_ram.sv -----
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module wbn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- sv/wbn_div.sv -----
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wbn_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wbn_pkg::div_req_t         req,
	output logic                      done,
	output logic [wbn_pkg::DVD_W-1:0] quotient
);
	localparam int CW = $clog2(wbn_pkg::DVD_W);

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic [wbn_pkg::DVS_W-1:0] rem_q;
	logic [wbn_pkg::DVS_W-1:0] dvs_q;
	logic [wbn_pkg::DVD_W-1:0] quo_q;
	logic [wbn_pkg::DVS_W:0]   rem_sh;
	logic [wbn_pkg::DVS_W+1:0] dif;

	assign rem_sh = {rem_q, quo_q[wbn_pkg::DVD_W-1]};
	assign dif = {1'b0, rem_sh} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(wbn_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvs_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			if (!dif[wbn_pkg::DVS_W+1]) begin
				rem_q <= dif[wbn_pkg::DVS_W-1:0];
				quo_q <= {quo_q[wbn_pkg::DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[wbn_pkg::DVS_W-1:0];
				quo_q <= {quo_q[wbn_pkg::DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ----- sv/windowed_baseline_normalizer.sv -----
// top level of the windowed baseline normalizer
`timescale 1ns / 1ps
// Add and clear give no result; the block is ready again in the next cycle. Normalize
// and update hold in_ready low while they run: update reads the history memory one entry
// per cycle, and both commands then run up to four (update) or two (normalize) divisions
// through one shared divider that makes one quotient bit per cycle. A result waits in an
// output register; add and clear items are taken meanwhile.
module windowed_baseline_normalizer #(
	parameter int HISTORY_DEPTH = wbn_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [wbn_pkg::DAYS_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  func,
	input  logic [15:0]                 heart_rate,
	input  logic [15:0]                 hrv_value,
	input  logic [15:0]                 skin_cond,
	input  logic [15:0]                 body_temp,
	input  logic [3:0]                  present_mask,
	input  logic [31:0]                 now_seconds,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [15:0]                 norm_hr,
	output logic [15:0]                 norm_hrv,
	output logic [15:0]                 norm_sc,
	output logic [15:0]                 norm_temp,
	output logic [3:0]                  norm_mask,
	output logic [8:0]                  sample_count,
	output logic [15:0]                 base_hr,
	output logic [15:0]                 base_hrv,
	output logic [15:0]                 base_sc,
	output logic [15:0]                 base_temp
);
	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = wbn_pkg::CH_W + CW;
	localparam int RW = 4 * wbn_pkg::CH_W + wbn_pkg::STAMP_W + wbn_pkg::MASK_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_WALK = 6'b000010,
		S_NORM = 6'b000100,
		S_DIVS = 6'b001000,
		S_DIVW = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t state_q;
	logic [wbn_pkg::DAYS_W-1:0] window_days_q;
	logic [AW-1:0] wr_idx_q;
	logic [CW-1:0] ent_cnt_q;
	logic [CW-1:0] rd_ptr_q;
	logic          rd_vld_s1;
	logic [CW-1:0] inwin_q;
	logic [CW-1:0] last_cnt_q;
	logic [SW-1:0] sum_q [4];
	logic [CW-1:0] cnt_q [4];
	logic [15:0]   base_q [4];
	logic [15:0]   val_q [4];
	logic [15:0]   res_q [4];
	logic [1:0]    func_q;
	logic [3:0]    mask_q;
	logic [31:0]   now_q;
	logic [wbn_pkg::SPAN_W-1:0] span_q;
	logic [1:0]    ch_q;
	logic          hr_lo_q;
	logic          hr_hi_q;
	logic [18:0]   hr_n_q;
	logic [15:0]   hr_q0_q;
	logic          out_valid_q;
	logic [15:0]   o_nh_q, o_nv_q, o_ns_q, o_nt_q;
	logic [3:0]    o_nm_q;
	logic [8:0]    o_cnt_q;
	logic [15:0]   o_base_q [4];

	logic          accept;
	logic          issue;
	logic [RW-1:0] ram_wdata;
	logic [RW-1:0] ram_rdata;
	logic [31:0]   rd_stamp;
	logic [3:0]    rd_mask;
	logic          rd_in_win;
	logic          need;
	logic          walk_end;
	logic          out_load;
	wbn_pkg::div_req_t div_req;
	logic          div_done;
	logic [wbn_pkg::DVD_W-1:0] div_quo;
	logic [16:0]   lim;
	logic [16:0]   vmin;
	logic signed [16:0] hr_diff;
	logic signed [24:0] hr_n;
	logic [34:0]   hr_prod;
	logic [19:0]   hr_rem;
	logic [15:0]   hr_fix;
	logic signed [16:0] t_diff;
	logic signed [24:0] t_n;
	logic [15:0]   t_val;
	logic [3:0]    nm;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign issue = (state_q == S_WALK) && (rd_ptr_q < ent_cnt_q);
	assign walk_end = (state_q == S_WALK) && !issue && !rd_vld_s1;
	assign ram_wdata = {present_mask, now_seconds, body_temp, skin_cond, hrv_value, heart_rate};

	wbn_ram #(.WIDTH(RW), .DEPTH(HISTORY_DEPTH)) u_hist (
		.clk  (clk),
		.we   (accept && func == wbn_pkg::FUNC_ADD),
		.waddr(wr_idx_q),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(rd_ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_stamp = ram_rdata[4*16 +: 32];
	assign rd_mask = ram_rdata[4*16+32 +: 4];
	assign rd_in_win = ({1'b0, rd_stamp} + 33'(span_q)) >= {1'b0, now_q};

	always_comb begin
		lim = {base_q[ch_q], 1'b0};
		vmin = ({1'b0, val_q[ch_q]} < lim) ? {1'b0, val_q[ch_q]} : lim;
		div_req.start = (state_q == S_DIVS) && need;
		if (func_q == wbn_pkg::FUNC_UPDATE) begin
			need = (cnt_q[ch_q] != '0);
			div_req.dividend = wbn_pkg::DVD_W'(sum_q[ch_q]);
			div_req.divisor = wbn_pkg::DVS_W'(cnt_q[ch_q]);
		end else begin
			need = (ch_q == 2'd1 || ch_q == 2'd2) && mask_q[ch_q] && (base_q[ch_q] != '0);
			div_req.dividend = wbn_pkg::DVD_W'({vmin, 14'b0});
			div_req.divisor = base_q[ch_q];
		end
	end

	wbn_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (div_req),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		hr_diff = $signed({1'b0, val_q[0]}) - $signed({1'b0, base_q[0]});
		hr_n = 25'sd245760 + ({{8{hr_diff[16]}}, hr_diff} <<< 5);
		hr_prod = 35'(hr_n[18:0]) * 35'd34952;
		hr_rem = {1'b0, hr_n_q} - (({4'b0, hr_q0_q} << 4) - {4'b0, hr_q0_q});
		hr_fix = (hr_rem >= 20'd15) ? hr_q0_q + 16'd1 : hr_q0_q;
		t_diff = $signed({1'b0, val_q[3]}) - $signed({1'b0, base_q[3]});
		t_n = 25'sd16384 + ({{8{t_diff[16]}}, t_diff} <<< 6);
		if (t_n[24]) begin
			t_val = '0;
		end else if (t_n > 25'sd32768) begin
			t_val = wbn_pkg::Q15_ONE[15:0];
		end else begin
			t_val = t_n[15:0];
		end
		for (int c = 0; c < 4; c++) begin
			nm[c] = (func_q == wbn_pkg::FUNC_NORM) && mask_q[c] && (base_q[c] != '0);
		end
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			window_days_q <= wbn_pkg::WINDOW_RESET;
			wr_idx_q <= '0;
			ent_cnt_q <= '0;
			rd_ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			last_cnt_q <= '0;
			ch_q <= '0;
			out_valid_q <= 1'b0;
			base_q[0] <= wbn_pkg::BASE_HR_RESET;
			base_q[1] <= wbn_pkg::BASE_HRV_RESET;
			base_q[2] <= wbn_pkg::BASE_SC_RESET;
			base_q[3] <= wbn_pkg::BASE_TEMP_RESET;
		end else begin
			if (cfg_we) begin
				window_days_q <= cfg_wdata;
			end
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (func)
							wbn_pkg::FUNC_ADD: begin
								wr_idx_q <= (wr_idx_q == AW'(HISTORY_DEPTH - 1)) ?
									'0 : wr_idx_q + 1'b1;
								if (ent_cnt_q != CW'(HISTORY_DEPTH)) begin
									ent_cnt_q <= ent_cnt_q + 1'b1;
								end
							end
							wbn_pkg::FUNC_CLEAR: begin
								wr_idx_q <= '0;
								ent_cnt_q <= '0;
							end
							wbn_pkg::FUNC_UPDATE: begin
								rd_ptr_q <= '0;
								state_q <= S_WALK;
							end
							default: begin
								state_q <= S_NORM;
							end
						endcase
					end
				end
				S_WALK: begin
					if (walk_end) begin
						ch_q <= '0;
						if (inwin_q == '0) begin
							state_q <= S_FIN;
						end else begin
							last_cnt_q <= inwin_q;
							state_q <= S_DIVS;
						end
					end
				end
				S_NORM: begin
					ch_q <= '0;
					state_q <= S_DIVS;
				end
				S_DIVS: begin
					if (need) begin
						state_q <= S_DIVW;
					end else if (ch_q == 2'd3) begin
						state_q <= S_FIN;
					end else begin
						ch_q <= ch_q + 1'b1;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						if (func_q == wbn_pkg::FUNC_UPDATE) begin
							base_q[ch_q] <= div_quo[15:0];
						end
						if (ch_q == 2'd3) begin
							state_q <= S_FIN;
						end else begin
							ch_q <= ch_q + 1'b1;
							state_q <= S_DIVS;
						end
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			mask_q <= present_mask;
			now_q <= now_seconds;
			val_q[0] <= heart_rate;
			val_q[1] <= hrv_value;
			val_q[2] <= skin_cond;
			val_q[3] <= body_temp;
			span_q <= wbn_pkg::SPAN_W'(window_days_q) * wbn_pkg::SPAN_W'(wbn_pkg::SEC_PER_DAY);
			inwin_q <= '0;
			for (int c = 0; c < 4; c++) begin
				sum_q[c] <= '0;
				cnt_q[c] <= '0;
			end
		end else if (rd_vld_s1 && rd_in_win) begin
			inwin_q <= inwin_q + 1'b1;
			for (int c = 0; c < 4; c++) begin
				if (rd_mask[c]) begin
					sum_q[c] <= sum_q[c] + SW'(ram_rdata[16*c +: 16]);
					cnt_q[c] <= cnt_q[c] + 1'b1;
				end
			end
		end
		if (state_q == S_NORM) begin
			hr_lo_q <= hr_n[24] || (hr_n == 25'sd0);
			hr_hi_q <= hr_n >= 25'sd491520;
			hr_n_q <= hr_n[18:0];
			hr_q0_q <= hr_prod[34:19];
		end
		if (state_q == S_DIVW && div_done) begin
			res_q[ch_q] <= div_quo[15:0];
		end
		if (out_load) begin
			if (!nm[0] || hr_lo_q) begin
				o_nh_q <= '0;
			end else if (hr_hi_q) begin
				o_nh_q <= wbn_pkg::Q15_ONE[15:0];
			end else begin
				o_nh_q <= hr_fix;
			end
			o_nv_q <= nm[1] ? res_q[1] : '0;
			o_ns_q <= nm[2] ? res_q[2] : '0;
			o_nt_q <= nm[3] ? t_val : '0;
			o_nm_q <= nm;
			o_cnt_q <= 9'(last_cnt_q);
			for (int c = 0; c < 4; c++) begin
				o_base_q[c] <= base_q[c];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign norm_hr = o_nh_q;
	assign norm_hrv = o_nv_q;
	assign norm_sc = o_ns_q;
	assign norm_temp = o_nt_q;
	assign norm_mask = o_nm_q;
	assign sample_count = o_cnt_q;
	assign base_hr = o_base_q[0];
	assign base_hrv = o_base_q[1];
	assign base_sc = o_base_q[2];
	assign base_temp = o_base_q[3];
endmodule

// ----- sv/wbn_chk.sv -----
// port checker for the windowed baseline normalizer and its bind
`timescale 1ns / 1ps
module wbn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  func,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] norm_hr,
	input logic [15:0] norm_hrv,
	input logic [15:0] norm_sc,
	input logic [15:0] norm_temp,
	input logic [3:0]  norm_mask,
	input logic [15:0] base_hr
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(norm_mask) && $stable(norm_hr)
			&& $stable(base_hr))
		else $error("result changed while stalled");

	a_q15_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_hr <= 16'd32768 && norm_hrv <= 16'd32768
			&& norm_sc <= 16'd32768 && norm_temp <= 16'd32768)
		else $error("normalized value above one");

	a_mask_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (norm_mask[0] || norm_hr == '0) && (norm_mask[1] || norm_hrv == '0)
			&& (norm_mask[2] || norm_sc == '0) && (norm_mask[3] || norm_temp == '0))
		else $error("invalid channel not zero");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == wbn_pkg::FUNC_UPDATE || func == wbn_pkg::FUNC_NORM)
			|=> !in_ready)
		else $error("took item while computing");
endmodule

bind windowed_baseline_normalizer wbn_chk u_wbn_chk (.*);
